// ===== src/lsus_pkg.sv =====
package lsus_pkg;

	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int WORD_W = 32;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [CNT_W-1:0] count_t;

	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_SEARCH = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_DUP   = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// shift command shared by every cell of the chain
	typedef struct packed {
		logic push;
		logic pop;
	} shift_ctl_t;

endpackage

// ===== src/lsus_cell.sv =====
module lsus_cell import lsus_pkg::*; (
	input  logic       clk,
	input  shift_ctl_t ctl,
	input  logic       occupied,
	input  word_t      key,
	input  word_t      from_above,
	input  word_t      from_below,
	output word_t      data,
	output logic       match
);

	word_t data_q;

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			data_q <= from_above;
		end else if (ctl.pop) begin
			data_q <= from_below;
		end
	end

	assign data  = data_q;
	assign match = occupied && (data_q == key);

endmodule

// ===== src/lifo_stack_unique_search.sv =====
// lifo_stack_unique_search
// A bounded stack of signed 32-bit words held in a chain of cells, top in
// cell 0. Each input word carries op (push, pop, search) and value; each
// accepted input word gives exactly one output word with status,
// popped_value and found.
// Input channel: in_valid/in_stall. Output channel: out_valid/out_stall.
// A word is accepted at a clock edge where valid is high and stall is low.
// The result sits in the output register the cycle after the input word
// is accepted. One word is taken per cycle while in_stall is low; every
// cell compares its entry with the key in the same cycle and the chain
// shifts down on push and up on pop.
// unique_mode is written through unique_mode_we/unique_mode_wdata, by the
// user only while the block is idle (not enforced by the block); with it
// set, a push of a value already held is rejected with the duplicate status.
// Reset (arst_n low) empties the stack, clears unique_mode and out_valid.
// While the receiver stalls a pending result, the output holds and in_stall
// is raised, so no further word is taken.
module lifo_stack_unique_search import lsus_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        unique_mode_we,
	input  logic        unique_mode_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic signed [31:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic signed [31:0] popped_value,
	output logic        found
);

	logic       unique_mode_q;
	count_t     count_q;
	logic       out_valid_q;
	status_t    status_q;
	word_t      popped_q;
	logic       found_q;

	word_t      cell_data [DEPTH];
	logic [DEPTH-1:0] cell_match;
	shift_ctl_t ctl;
	logic       fire;
	logic       any_match;
	logic       is_empty;
	logic       is_full;
	status_t    status_d;
	word_t      popped_d;
	logic       found_d;
	op_t        op_in;

	assign op_in     = op_t'(op);
	assign in_stall  = out_valid_q && out_stall;
	assign fire      = in_valid && !in_stall;
	assign is_empty  = (count_q == '0);
	assign is_full   = (count_q == CNT_W'(DEPTH));
	assign any_match = |cell_match;

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			word_t above;
			word_t below;
			if (i == 0) begin : g_top
				assign above = value;
			end else begin : g_mid
				assign above = cell_data[i-1];
			end
			if (i == DEPTH - 1) begin : g_bot
				assign below = cell_data[i];
			end else begin : g_inner
				assign below = cell_data[i+1];
			end
			lsus_cell u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.occupied   (count_q > CNT_W'(i)),
				.key        (value),
				.from_above (above),
				.from_below (below),
				.data       (cell_data[i]),
				.match      (cell_match[i])
			);
		end
	endgenerate

	always_comb begin
		ctl      = '0;
		status_d = ST_OK;
		popped_d = '0;
		found_d  = 1'b0;
		case (op_in)
			OP_PUSH: begin
				if (is_full) begin
					status_d = ST_FULL;
				end else if (unique_mode_q && !is_empty && any_match) begin
					status_d = ST_DUP;
				end else begin
					ctl.push = fire;
				end
			end
			OP_POP: begin
				if (is_empty) begin
					status_d = ST_EMPTY;
				end else begin
					ctl.pop  = fire;
					popped_d = cell_data[0];
				end
			end
			OP_SEARCH: begin
				if (is_empty) begin
					status_d = ST_EMPTY;
				end else begin
					found_d = any_match;
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unique_mode_q <= 1'b0;
			count_q       <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (unique_mode_we) begin
				unique_mode_q <= unique_mode_wdata;
			end
			if (ctl.push) begin
				count_q <= count_q + 1'b1;
			end else if (ctl.pop) begin
				count_q <= count_q - 1'b1;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (fire) begin
			status_q <= status_d;
			popped_q <= popped_d;
			found_q  <= found_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign popped_value = popped_q;
	assign found        = found_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push |=> count_q == $past(count_q) + 1'b1)
		else $error("push did not grow the stack");

	a_pop_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |=> count_q == $past(count_q) - 1'b1)
		else $error("pop did not shrink the stack");

	a_dup_needs_mode: assert property (@(posedge clk) disable iff (!arst_n)
		fire && status_d == ST_DUP |-> unique_mode_q && !is_empty)
		else $error("duplicate status outside unique mode");

	a_found_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		fire && found_d |-> !is_empty && op_in == OP_SEARCH)
		else $error("found raised without a search on a filled stack");

endmodule
